### rtl/ptt_pkg.sv
package ptt_pkg;

   // transaction opcodes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_KILL = 2'd2;

   // field widths
   localparam int unsigned ID_W    = 4;
   localparam int unsigned IVL_W   = 16;
   localparam int unsigned TICK_W  = 32;

   // at most this many firing results per tick
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned FIRE_CNT_W  = 5;

   // one table entry: interval over phase
   typedef struct packed {
      logic [IVL_W-1:0] interval;
      logic [IVL_W-1:0] phase;
   } entry_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIV_TICK,
      ST_NEXT,
      ST_DIV_SET,
      ST_FLUSH
   } state_type;

endpackage

### rtl/ptt_ram.sv
module ptt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ptt_mod.sv
module ptt_mod
   import ptt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [TICK_W-1:0] dividend,
   input  logic [IVL_W-1:0]  divisor,
   output logic              done,
   output logic [IVL_W-1:0]  remainder
);

   localparam int unsigned STEP_W = $clog2(TICK_W);

   logic [TICK_W-1:0] dvd_ff, dvd_in;
   logic [IVL_W-1:0]  div_ff, div_in;
   logic [IVL_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [IVL_W:0]    trial;
   logic              fits;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[TICK_W-1]};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = STEP_W'(TICK_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[TICK_W-2:0], 1'b0};
         rem_in = fits ? IVL_W'(trial - {1'b0, div_ff}) : trial[IVL_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/periodic_timer_table.sv
// kill, bad id and unused opcodes are handled without leaving idle; set runs one 32-step modulo
// tick: scans the entries in order, and each enabled entry runs the shared
//   bit-serial modulo unit for 32 steps; one transaction at a time
// results come one per strobe cycle during the tick scan; the receiver cannot stall
// reset (synchronous, active high) disables all timers and clears the tick count
module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int unsigned NUM_TIMERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [ID_W-1:0]   req_timer_id,
   input  logic [IVL_W-1:0]  req_interval,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_fired_id,
   output logic [TICK_W-1:0] rsp_tick_count,
   output logic              rsp_last
);

   localparam int unsigned IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int unsigned ENTRY_W = $bits(entry_type);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [ID_W-1:0]   id_ff;
   logic [IVL_W-1:0]  ivl_ff;
   logic [IVL_W-1:0]  phase_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [NUM_TIMERS-1:0] valid_ff;
   logic [IDX_W-1:0]  pend_ff;
   logic              pend_valid_ff;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_fired_id_ff;
   logic [TICK_W-1:0] rsp_tick_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              id_ok;
   logic              do_kill;
   logic              do_set;
   logic              ram_rd;
   logic              ram_wr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic              mod_go;
   logic [IVL_W-1:0]  mod_divisor;
   logic              mod_done;
   logic [IVL_W-1:0]  mod_rem;
   logic              match;
   logic              scan_end;
   logic              emit;
   logic              emit_last;
   logic [IVL_W-1:0]  new_phase;

   assign accept   = start && (state_ff == ST_IDLE);
   assign id_ok    = (32'(req_timer_id) < NUM_TIMERS);
   assign rd_entry = entry_type'(ram_rdata);
   assign scan_end = (idx_ff == IDX_W'(NUM_TIMERS - 1))
                     || (fire_cnt_ff == FIRE_CNT_W'(MAX_RESULTS));
   // phase = (tick mod I + I - 1) mod I, i.e. one step back around the period
   assign new_phase = (mod_rem == '0) ? (ivl_ff - 1'b1) : (mod_rem - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_TICK) begin
                  state_in = ST_READ;
               end else if (req_opcode == OP_SET && id_ok && req_interval != '0) begin
                  state_in = ST_DIV_SET;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = valid_ff[idx_ff] ? ST_DIV_TICK : ST_NEXT;
         end
         ST_DIV_TICK: begin
            if (mod_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            state_in = scan_end ? ST_FLUSH : ST_READ;
         end
         ST_DIV_SET: begin
            if (mod_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      do_kill     = 1'b0;
      do_set      = 1'b0;
      ram_rd      = 1'b0;
      ram_wr      = 1'b0;
      mod_go      = 1'b0;
      mod_divisor = rd_entry.interval;
      match       = 1'b0;
      emit        = 1'b0;
      emit_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && id_ok) begin
               if (req_opcode == OP_KILL
                   || (req_opcode == OP_SET && req_interval == '0)) begin
                  do_kill = 1'b1;
               end else if (req_opcode == OP_SET) begin
                  do_set      = 1'b1;
                  mod_go      = 1'b1;
                  mod_divisor = req_interval;
               end
            end
         end
         ST_READ: begin
            ram_rd = 1'b1;
         end
         ST_EVAL: begin
            mod_go = valid_ff[idx_ff];
         end
         ST_DIV_TICK: begin
            match = mod_done && (mod_rem == phase_ff);
            emit  = match && pend_valid_ff;
         end
         ST_DIV_SET: begin
            ram_wr = mod_done;
         end
         ST_FLUSH: begin
            emit      = pend_valid_ff;
            emit_last = 1'b1;
         end
         default: begin
            match = 1'b0;
         end
      endcase
   end

   assign wr_entry.interval = ivl_ff;
   assign wr_entry.phase    = new_phase;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         tick_ff       <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
         if (do_kill) begin
            valid_ff[IDX_W'(req_timer_id)] <= 1'b0;
         end
         if (ram_wr) begin
            valid_ff[IDX_W'(id_ff)] <= 1'b1;
         end
         if (match) begin
            pend_valid_ff <= 1'b1;
            fire_cnt_ff   <= fire_cnt_ff + 1'b1;
         end
         if (state_ff == ST_NEXT && !scan_end) begin
            idx_ff <= idx_ff + 1'b1;
         end
         // end of the tick scan
         if (state_ff == ST_FLUSH) begin
            idx_ff        <= '0;
            pend_valid_ff <= 1'b0;
            fire_cnt_ff   <= '0;
            tick_ff       <= tick_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (do_set) begin
         id_ff  <= req_timer_id;
         ivl_ff <= req_interval;
      end
      if (state_ff == ST_EVAL) begin
         phase_ff <= rd_entry.phase;
      end
      if (match) begin
         pend_ff <= idx_ff;
      end
      if (emit) begin
         rsp_fired_id_ff <= ID_W'(pend_ff);
         rsp_tick_ff     <= tick_ff;
         rsp_last_ff     <= emit_last;
      end
   end

   // interval and phase storage
   ptt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (IDX_W'(id_ff)),
      .wr_data (wr_entry),
      .rd_en   (ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // shared modulo unit
   ptt_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (mod_go),
      .dividend  (tick_ff),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_id   = rsp_fired_id_ff;
   assign rsp_tick_count = rsp_tick_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   // a result not marked last means the scan is still running
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-last result while idle");

   // set and kill transactions never produce a result
   a_no_rsp_on_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode != OP_TICK |=> !rsp_valid)
      else $error("result after set or kill");

   // the modulo unit only finishes while the sequencer waits for it
   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == ST_DIV_TICK || state_ff == ST_DIV_SET)
      else $error("modulo result outside a divide state");

   // the tick count only advances at the end of a tick scan
   a_tick_hold: assert property (@(posedge clock) disable iff (reset || $past(reset))
      $past(state_ff) != ST_FLUSH |-> $stable(tick_ff))
      else $error("tick count changed outside flush");
`endif

endmodule
